>>> src/c8ie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_pkg: shared types and constants for the CHIP-8 instruction executor
// Opcode groups, ALU function codes, widths, stack depth and the result
// word layout.
// ----------------------------------------------------------------------------
package c8ie_pkg;

    localparam int PC_W        = 12;
    localparam int REG_W       = 8;
    localparam int IDX_W       = 4;
    localparam int INSTR_W     = 16;
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CFG_W       = 32;
    localparam int ADDR_W      = 3;

    localparam logic [PC_W-1:0]    START_ADDR_RST = 12'h200;
    localparam logic [INSTR_W-1:0] INS_CLS        = 16'h00E0;
    localparam logic [INSTR_W-1:0] INS_RET        = 16'h00EE;
    localparam logic [IDX_W-1:0]   IDX_VF         = 4'hF;

    // Register index of the configuration port
    localparam logic [0:0] CFG_START_ADDR = 1'b0;

    // Top nibble of the opcode
    typedef enum logic [3:0] {
        OP_SYS  = 4'h0,
        OP_JP   = 4'h1,
        OP_CALL = 4'h2,
        OP_SE   = 4'h3,
        OP_SNE  = 4'h4,
        OP_SER  = 4'h5,
        OP_LD   = 4'h6,
        OP_ADD  = 4'h7,
        OP_ALU  = 4'h8
    } op_t;

    // Low nibble of the 8xyN group
    typedef enum logic [3:0] {
        ALU_MOV  = 4'h0,
        ALU_OR   = 4'h1,
        ALU_AND  = 4'h2,
        ALU_XOR  = 4'h3,
        ALU_ADD  = 4'h4,
        ALU_SUB  = 4'h5,
        ALU_SHR  = 4'h6,
        ALU_SUBN = 4'h7
    } alu_t;

    // Result word, first member in the highest bits
    typedef struct packed {
        logic             unsupported;
        logic             display_clear;
        logic             flag_value;
        logic             flag_write_valid;
        logic [REG_W-1:0] reg_write_value;
        logic [IDX_W-1:0] reg_write_index;
        logic             reg_write_valid;
        logic [PC_W-1:0]  next_pc;
    } result_t;

    localparam int RES_W   = $bits(result_t);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

>>> src/chip8_instruction_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_execute: CHIP-8 opcode executor
// Executes one 16-bit opcode per word against V0..VF, the program counter
// and a return stack, and reports one result word per opcode.
// ----------------------------------------------------------------------------
// The block takes one opcode per clock cycle and sustains that rate while the
// result side does not stall it; an opcode is registered into stage 1, its
// result word into the output register. The rate is set by the register file
// memory: V0..VE are read at the edge that takes an opcode, and the next stage
// computes and writes back, with a one-deep forward of the last write covering
// an opcode that reads what the one ahead of it writes. VF lives in a flip-flop.
// The return stack is a second memory with the same read-then-write scheme.
// After reset all registers read as zero at once (no clearing pass), the stack
// pointer is zero and the program counter is 0x200. The boot address register
// is stored and can be read back; reset restores it to 0x200 as well.
module chip8_instruction_execute (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [c8ie_pkg::ADDR_W-1:0]    paddr,
    input  logic [c8ie_pkg::CFG_W-1:0]     pwdata,
    output logic [c8ie_pkg::CFG_W-1:0]     prdata,
    output logic                           pready,
    // opcode stream; tdata: instruction[15:0]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [c8ie_pkg::INSTR_W-1:0]   s_tdata,
    // result stream; tdata: next_pc[11:0], reg_write_valid[12],
    // reg_write_index[16:13], reg_write_value[24:17], flag_write_valid[25],
    // flag_value[26], display_clear[27], unsupported[28], zero[31:29]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [c8ie_pkg::TDATA_W-1:0]   m_tdata
);
    import c8ie_pkg::*;

    // configuration
    logic [PC_W-1:0]    start_addr_reg;
    logic               cfg_we;

    // stage 0 state (updated at accept)
    logic [SP_W-1:0]    sp_reg;
    logic [SP_W-1:0]    sp_inc;
    logic [SP_W-1:0]    sp_dec;
    logic               s_acc;
    logic [IDX_W-1:0]   in_x;
    logic [IDX_W-1:0]   in_y;
    logic               in_ret;
    logic               in_call;

    // memories
    logic [REG_W-1:0]   rf_mem [0:15];
    logic [PC_W-1:0]    stk_mem [0:STACK_DEPTH-1];
    logic [15:0]        rf_vld_reg;

    // stage 1 (execute)
    logic               st1_vld_reg;
    logic [INSTR_W-1:0] instr_reg;
    logic [REG_W-1:0]   vx_rd_reg;
    logic [REG_W-1:0]   vy_rd_reg;
    logic               vx_ok_reg;
    logic               vy_ok_reg;
    logic [PC_W-1:0]    stk_rd_reg;
    logic [SP_W-1:0]    stk_addr_reg;

    // forwarding of the last write into each memory
    logic               rf_fwd_vld_reg;
    logic [IDX_W-1:0]   rf_fwd_idx_reg;
    logic [REG_W-1:0]   rf_fwd_data_reg;
    logic               stk_fwd_vld_reg;
    logic [SP_W-1:0]    stk_fwd_addr_reg;
    logic [PC_W-1:0]    stk_fwd_data_reg;

    // architectural state held in flip-flops
    logic [PC_W-1:0]    pc_reg;
    logic [PC_W-1:0]    pc_next;
    logic [REG_W-1:0]   vf_reg;
    logic [REG_W-1:0]   vf_next;

    // output register
    logic               m_tvalid_reg;
    result_t            m_res_reg;

    // execute logic
    logic               adv;
    op_t                op;
    logic [IDX_W-1:0]   x;
    logic [IDX_W-1:0]   y;
    logic [REG_W-1:0]   kk;
    logic [PC_W-1:0]    nnn;
    logic [REG_W-1:0]   a;
    logic [REG_W-1:0]   b;
    logic [REG_W-1:0]   a2;
    logic [REG_W-1:0]   b2;
    logic [REG_W:0]     sum;
    logic [PC_W-1:0]    pc_inc;
    logic [PC_W-1:0]    pc_skip;
    logic [PC_W-1:0]    stk_val;
    logic [REG_W-1:0]   res;
    logic               rv;
    logic               fv;
    logic               fl;
    logic               clr;
    logic               uns;
    logic               stk_we;
    logic               rf_we;
    result_t            res_word;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == CFG_START_ADDR);

    always_comb begin
        prdata = '0;
        if (paddr[2] == CFG_START_ADDR) begin
            prdata = CFG_W'(start_addr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_addr_reg <= START_ADDR_RST;
        end else if (cfg_we) begin
            start_addr_reg <= pwdata[PC_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign adv      = st1_vld_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !st1_vld_reg || adv;
    assign s_acc    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // stage 0: decode stack moves, issue memory reads
    // ------------------------------------------------------------------
    assign in_x    = s_tdata[11:8];
    assign in_y    = s_tdata[7:4];
    assign in_ret  = (s_tdata == INS_RET);
    assign in_call = (op_t'(s_tdata[15:12]) == OP_CALL);

    assign sp_inc = (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + SP_W'(1);
    assign sp_dec = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - SP_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            st1_vld_reg <= 1'b0;
        end else begin
            if (s_acc && in_ret) begin
                sp_reg <= sp_dec;
            end else if (s_acc && in_call) begin
                sp_reg <= sp_inc;
            end
            if (s_acc) begin
                st1_vld_reg <= 1'b1;
            end else if (adv) begin
                st1_vld_reg <= 1'b0;
            end
        end
    end

    // read ports: data registered at the accept edge
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            instr_reg    <= s_tdata;
            vx_rd_reg    <= rf_mem[in_x];
            vy_rd_reg    <= rf_mem[in_y];
            vx_ok_reg    <= rf_vld_reg[in_x];
            vy_ok_reg    <= rf_vld_reg[in_y];
            stk_rd_reg   <= stk_mem[sp_dec];
            stk_addr_reg <= in_ret ? sp_dec : sp_reg;
        end
    end

    // write ports
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[x] <= res;
        end
        if (adv && stk_we) begin
            stk_mem[stk_addr_reg] <= pc_inc;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: operand select with forwarding, execute
    // ------------------------------------------------------------------
    assign op  = op_t'(instr_reg[15:12]);
    assign x   = instr_reg[11:8];
    assign y   = instr_reg[7:4];
    assign kk  = instr_reg[7:0];
    assign nnn = instr_reg[PC_W-1:0];

    always_comb begin
        if (x == IDX_VF) begin
            a = vf_reg;
        end else if (rf_fwd_vld_reg && rf_fwd_idx_reg == x) begin
            a = rf_fwd_data_reg;
        end else begin
            a = vx_ok_reg ? vx_rd_reg : '0;
        end
        if (y == IDX_VF) begin
            b = vf_reg;
        end else if (rf_fwd_vld_reg && rf_fwd_idx_reg == y) begin
            b = rf_fwd_data_reg;
        end else begin
            b = vy_ok_reg ? vy_rd_reg : '0;
        end
    end

    assign stk_val = (stk_fwd_vld_reg && stk_fwd_addr_reg == stk_addr_reg) ?
                     stk_fwd_data_reg : stk_rd_reg;
    assign sum     = {1'b0, a} + {1'b0, b};
    assign pc_inc  = pc_reg + PC_W'(2);
    assign pc_skip = pc_reg + PC_W'(4);

    always_comb begin
        pc_next = pc_inc;
        rv      = 1'b0;
        fv      = 1'b0;
        fl      = 1'b0;
        clr     = 1'b0;
        uns     = 1'b0;
        stk_we  = 1'b0;
        res     = '0;
        a2      = a;
        b2      = b;
        case (op)
            OP_SYS: begin
                if (instr_reg == INS_CLS) begin
                    clr = 1'b1;
                end else if (instr_reg == INS_RET) begin
                    pc_next = stk_val;
                end else begin
                    uns = 1'b1;
                end
            end
            OP_JP: begin
                pc_next = nnn;
            end
            OP_CALL: begin
                stk_we  = 1'b1;
                pc_next = nnn;
            end
            OP_SE: begin
                if (a == kk) pc_next = pc_skip;
            end
            OP_SNE: begin
                if (a != kk) pc_next = pc_skip;
            end
            OP_SER: begin
                if (instr_reg[3:0] != 4'h0) begin
                    uns = 1'b1;
                end else if (a == b) begin
                    pc_next = pc_skip;
                end
            end
            OP_LD: begin
                rv  = 1'b1;
                res = kk;
            end
            OP_ADD: begin
                rv  = 1'b1;
                res = a + kk;
            end
            OP_ALU: begin
                rv = 1'b1;
                case (alu_t'(instr_reg[3:0]))
                    ALU_MOV: res = b;
                    ALU_OR:  res = a | b;
                    ALU_AND: res = a & b;
                    ALU_XOR: res = a ^ b;
                    ALU_ADD: begin
                        fv  = 1'b1;
                        fl  = sum[REG_W];
                        res = sum[REG_W-1:0];
                    end
                    ALU_SUB: begin
                        // operands are read back after the flag lands in VF
                        fv  = 1'b1;
                        fl  = (a > b);
                        a2  = (x == IDX_VF) ? REG_W'(fl) : a;
                        b2  = (y == IDX_VF) ? REG_W'(fl) : b;
                        res = a2 - b2;
                    end
                    ALU_SHR: begin
                        fv  = 1'b1;
                        fl  = a[0];
                        a2  = (x == IDX_VF) ? REG_W'(fl) : a;
                        res = a2 >> 1;
                    end
                    ALU_SUBN: begin
                        fv  = 1'b1;
                        fl  = (b > a);
                        a2  = (x == IDX_VF) ? REG_W'(fl) : a;
                        b2  = (y == IDX_VF) ? REG_W'(fl) : b;
                        res = b2 - a2;
                    end
                    default: begin
                        rv  = 1'b0;
                        uns = 1'b1;
                    end
                endcase
            end
            default: begin
                uns = 1'b1;
            end
        endcase

        // flag first, then Vx overwrites it when x is VF
        vf_next = vf_reg;
        if (fv) vf_next = REG_W'(fl);
        if (rv && x == IDX_VF) vf_next = res;
    end

    assign rf_we = adv && rv && (x != IDX_VF);

    always_comb begin
        res_word.next_pc          = pc_next;
        res_word.reg_write_valid  = rv;
        res_word.reg_write_index  = rv ? x : '0;
        res_word.reg_write_value  = rv ? res : '0;
        res_word.flag_write_valid = fv;
        res_word.flag_value       = fl;
        res_word.display_clear    = clr;
        res_word.unsupported      = uns;
    end

    // ------------------------------------------------------------------
    // write back and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg          <= START_ADDR_RST;
            vf_reg          <= '0;
            rf_vld_reg      <= '0;
            rf_fwd_vld_reg  <= 1'b0;
            stk_fwd_vld_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (adv) begin
                pc_reg       <= pc_next;
                vf_reg       <= vf_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (rf_we) begin
                rf_vld_reg[x]  <= 1'b1;
                rf_fwd_vld_reg <= 1'b1;
            end
            if (adv && stk_we) begin
                stk_fwd_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_res_reg <= res_word;
        end
        if (rf_we) begin
            rf_fwd_idx_reg  <= x;
            rf_fwd_data_reg <= res;
        end
        if (adv && stk_we) begin
            stk_fwd_addr_reg <= stk_addr_reg;
            stk_fwd_data_reg <= pc_inc;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_res_reg);

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_vf_not_in_mem: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_we |-> (x != IDX_VF))
        else $error("register file memory written at the VF slot");

    a_flag_has_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (!m_res_reg.flag_write_valid || m_res_reg.reg_write_valid))
        else $error("flag write reported without a register write");

    a_uns_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_res_reg.unsupported |->
            !m_res_reg.reg_write_valid && !m_res_reg.display_clear)
        else $error("unsupported opcode reported a state change");

    a_sp_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_acc |=> $stable(sp_reg))
        else $error("stack pointer moved without an accepted word");

    a_pc_only_on_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(pc_reg))
        else $error("program counter moved without an executed word");

endmodule

>>> verif/chip8_exec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_exec_checker: result predictor and scoreboard for the CHIP-8 executor
// Watches the opcode, result and APB channels. Runs its own copy of V0..VF,
// the program counter and the return stack on every accepted opcode, queues
// the predicted result words and compares each accepted result word with the
// oldest one. Read-backs of the boot address register are checked against a
// shadow copy.
// ----------------------------------------------------------------------------
module chip8_exec_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [c8ie_pkg::ADDR_W-1:0]  paddr,
    input  logic [c8ie_pkg::CFG_W-1:0]   pwdata,
    input  logic [c8ie_pkg::CFG_W-1:0]   prdata,
    input  logic                         pready,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [c8ie_pkg::INSTR_W-1:0] s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [c8ie_pkg::TDATA_W-1:0] m_tdata,
    output int                           mismatches,
    output int                           results_due
);
    import c8ie_pkg::*;

    localparam logic [ADDR_W-1:0] START_ADDR_REG = ADDR_W'(CFG_START_ADDR) << 2;

    logic [REG_W-1:0] vreg      [16];
    logic [PC_W-1:0]  ret_stack [STACK_DEPTH];
    logic [PC_W-1:0]  prog_ctr;
    logic [PC_W-1:0]  start_addr_cfg;
    int               stack_ptr;
    int               err_count;
    result_t          result_words_due [$];

    initial begin
        mismatches  = 0;
        results_due = 0;
        err_count   = 0;
    end

    // Run one opcode against the local machine state and return its result word.
    function automatic result_t execute_opcode(input logic [INSTR_W-1:0] op);
        result_t          r;
        logic [IDX_W-1:0] x;
        logic [IDX_W-1:0] y;
        logic [3:0]       n;
        logic [REG_W-1:0] kk;
        logic [REG_W-1:0] a;
        logic [REG_W-1:0] b;
        logic [REG_W:0]   sum;
        logic [PC_W-1:0]  pc;
        logic             flag;
        r    = '0;
        x    = op[11:8];
        y    = op[7:4];
        n    = op[3:0];
        kk   = op[7:0];
        flag = 1'b0;
        pc   = prog_ctr + PC_W'(2);
        case (op[15:12])
            OP_SYS: begin
                if (op == INS_CLS) begin
                    r.display_clear = 1'b1;
                end else if (op == INS_RET) begin
                    stack_ptr = (stack_ptr + STACK_DEPTH - 1) % STACK_DEPTH;
                    pc        = ret_stack[stack_ptr];
                end else begin
                    r.unsupported = 1'b1;
                end
            end
            OP_JP: pc = op[PC_W-1:0];
            OP_CALL: begin
                ret_stack[stack_ptr] = pc;
                stack_ptr            = (stack_ptr + 1) % STACK_DEPTH;
                pc                   = op[PC_W-1:0];
            end
            OP_SE: if (vreg[x] == kk) pc = pc + PC_W'(2);
            OP_SNE: if (vreg[x] != kk) pc = pc + PC_W'(2);
            OP_SER: begin
                if (n != 4'h0) begin
                    r.unsupported = 1'b1;
                end else if (vreg[x] == vreg[y]) begin
                    pc = pc + PC_W'(2);
                end
            end
            OP_LD: begin
                vreg[x]           = kk;
                r.reg_write_valid = 1'b1;
            end
            OP_ADD: begin
                vreg[x]           = vreg[x] + kk;
                r.reg_write_valid = 1'b1;
            end
            OP_ALU: begin
                a                 = vreg[x];
                b                 = vreg[y];
                r.reg_write_valid = 1'b1;
                // flag goes into VF first; later reads see the updated file
                case (n)
                    ALU_MOV: vreg[x] = b;
                    ALU_OR:  vreg[x] = a | b;
                    ALU_AND: vreg[x] = a & b;
                    ALU_XOR: vreg[x] = a ^ b;
                    ALU_ADD: begin
                        sum          = {1'b0, a} + {1'b0, b};
                        flag         = sum[REG_W];
                        vreg[IDX_VF] = REG_W'(flag);
                        vreg[x]      = sum[REG_W-1:0];
                    end
                    ALU_SUB: begin
                        flag         = (a > b);
                        vreg[IDX_VF] = REG_W'(flag);
                        vreg[x]      = vreg[x] - vreg[y];
                    end
                    ALU_SHR: begin
                        flag         = a[0];
                        vreg[IDX_VF] = REG_W'(flag);
                        vreg[x]      = vreg[x] >> 1;
                    end
                    ALU_SUBN: begin
                        flag         = (b > a);
                        vreg[IDX_VF] = REG_W'(flag);
                        vreg[x]      = vreg[y] - vreg[x];
                    end
                    default: begin
                        r.reg_write_valid = 1'b0;
                        r.unsupported     = 1'b1;
                    end
                endcase
                if (n inside {ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN}) begin
                    r.flag_write_valid = 1'b1;
                    r.flag_value       = flag;
                end
            end
            default: r.unsupported = 1'b1;
        endcase
        prog_ctr  = pc;
        r.next_pc = pc;
        if (r.reg_write_valid) begin
            r.reg_write_index = x;
            r.reg_write_value = vreg[x];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) vreg[i] = '0;
            for (int i = 0; i < STACK_DEPTH; i++) ret_stack[i] = '0;
            prog_ctr       = START_ADDR_RST;
            start_addr_cfg = START_ADDR_RST;
            stack_ptr      = 0;
            result_words_due.delete();
        end else begin
            // pop before push: a word accepted now cannot answer this edge's opcode
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RES_W-1:0]);
                if (result_words_due.size() == 0) begin
                    $display("%0t: result word %h with no opcode outstanding", $time, m_tdata);
                    err_count++;
                end else begin
                    want = result_words_due.pop_front();
                    if (got !== want || m_tdata[TDATA_W-1:RES_W] !== '0) begin
                        $display("%0t: result mismatch, expected pc=%h rw=%b idx=%h val=%h fw=%b",
                                 $time, want.next_pc, want.reg_write_valid,
                                 want.reg_write_index, want.reg_write_value,
                                 want.flag_write_valid);
                        $display("    exp fv=%b clr=%b uns=%b | got pc=%h rw=%b idx=%h val=%h",
                                 want.flag_value, want.display_clear, want.unsupported,
                                 got.next_pc, got.reg_write_valid, got.reg_write_index,
                                 got.reg_write_value);
                        $display("    got fw=%b fv=%b clr=%b uns=%b pad=%b",
                                 got.flag_write_valid, got.flag_value, got.display_clear,
                                 got.unsupported, m_tdata[TDATA_W-1:RES_W]);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                result_words_due.push_back(execute_opcode(s_tdata));
            end
            if (psel && penable && pready && paddr == START_ADDR_REG) begin
                if (pwrite) begin
                    start_addr_cfg = pwdata[PC_W-1:0];
                end else if (prdata[PC_W-1:0] !== start_addr_cfg) begin
                    $display("%0t: boot address read mismatch, expected %h got %h",
                             $time, start_addr_cfg, prdata[PC_W-1:0]);
                    err_count++;
                end
            end
        end
        mismatches  <= err_count;
        results_due <= result_words_due.size();
    end

endmodule

>>> verif/chip8_instruction_execute_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_execute_tb: stimulus and verdict for the CHIP-8 executor
// Resets once, then runs phases separated by idle boot address writes and
// read-backs: a directed opcode set, then random opcode streams weighted
// toward well-formed instructions, with bursty input and a stalling result
// side including long hold-offs. The checker scores every result word.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_tb;
    import c8ie_pkg::*;

    localparam int   HOLD_CYCLES    = 300;
    localparam int   IDLE_LIMIT     = 4000;
    localparam int   PHASE_ITEMS    = 135;
    localparam int   NUM_PHASES     = 4;
    localparam logic [ADDR_W-1:0] START_ADDR_REG = ADDR_W'(CFG_START_ADDR) << 2;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [ADDR_W-1:0]  paddr    = '0;
    logic [CFG_W-1:0]   pwdata   = '0;
    logic [CFG_W-1:0]   prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [INSTR_W-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    int  mismatches;
    int  results_due;
    int  idle_cycles   = 0;
    int  words_sent    = 0;
    int  burst_left    = 0;
    bit  hold_off_req  = 1'b0;
    int  stk_ptr       = 0;
    bit  stk_written [STACK_DEPTH];

    always #2 aclk = ~aclk;

    chip8_instruction_execute u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    chip8_exec_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // Abort when neither channel moves a word for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: ready patterns that change now and then, plus long hold-offs on request.
    initial begin
        int         mode;
        int         left;
        int         ph;
        logic [7:0] pat;
        mode = 0;
        left = 0;
        ph   = 0;
        pat  = '1;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(16, 160);
                    pat  = 8'($urandom());
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        m_tready <= pat[ph % 8];
                        ph++;
                    end
                endcase
            end
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one opcode word; never pop a return stack entry that was not pushed.
    task automatic issue(input logic [INSTR_W-1:0] w);
        int below;
        int gap;
        below = (stk_ptr + STACK_DEPTH - 1) % STACK_DEPTH;
        if (w == INS_RET && !stk_written[below]) begin
            w = {OP_CALL, 12'($urandom())};
        end
        if (w[15:12] == OP_CALL) begin
            stk_written[stk_ptr] = 1'b1;
            stk_ptr              = (stk_ptr + 1) % STACK_DEPTH;
        end else if (w == INS_RET) begin
            stk_ptr = below;
        end
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Mostly well-formed opcodes; half of the skips get a preceding load so they can hit.
    task automatic issue_random();
        logic [IDX_W-1:0] x;
        logic [IDX_W-1:0] y;
        logic [REG_W-1:0] kk;
        logic [3:0]       n;
        int               r;
        x  = 4'($urandom());
        y  = 4'($urandom());
        kk = 8'($urandom());
        n  = 4'($urandom());
        r  = $urandom_range(0, 99);
        if (r < 8) begin
            issue(16'($urandom()));
        end else if (r < 14) begin
            case ($urandom_range(0, 2))
                0: issue(INS_CLS);
                1: issue(INS_RET);
                default: issue({OP_SYS, 12'($urandom())});
            endcase
        end else if (r < 19) begin
            issue({OP_JP, 12'($urandom())});
        end else if (r < 27) begin
            issue({OP_CALL, 12'($urandom())});
        end else if (r < 42) begin
            if ($urandom_range(0, 1) == 0) issue({OP_LD, x, kk});
            if ($urandom_range(0, 1) == 0) kk = kk ^ 8'($urandom_range(1, 255));
            issue({($urandom_range(0, 1) == 0) ? OP_SE : OP_SNE, x, kk});
        end else if (r < 50) begin
            if ($urandom_range(0, 1) == 0) begin
                issue({OP_LD, x, kk});
                issue({OP_LD, y, kk});
            end
            issue({OP_SER, x, y, ($urandom_range(0, 5) == 0) ? n : 4'h0});
        end else if (r < 60) begin
            issue({OP_LD, x, kk});
        end else if (r < 68) begin
            issue({OP_ADD, x, kk});
        end else if (r < 96) begin
            if ($urandom_range(0, 7) != 0) n[3] = 1'b0;
            issue({OP_ALU, x, y, n});
        end else begin
            issue({4'($urandom_range(9, 15)), 12'($urandom())});
        end
    endtask

    task automatic issue_directed();
        issue(16'h6000);   // V0 = 00
        issue(16'h61FF);   // V1 = FF
        issue(16'h7101);   // add wraps to 00, VF untouched
        issue(16'h62FF);
        issue(16'h6301);
        issue(16'h8234);   // add with carry out
        issue(16'h8135);   // sub with borrow
        issue(16'h8225);   // sub of equal values: flag stays 0
        issue(16'h8136);   // shift right, bit 0 into VF
        issue(16'h8317);   // reverse subtract
        issue(16'h8F34);   // Vx is VF: result overwrites the flag
        issue(16'h8120);
        issue(16'h8211);
        issue(16'h8322);
        issue(16'h8413);
        issue(16'h812E);   // 8xyN with N above 7
        issue(INS_CLS);
        issue(16'h0123);   // 0nnn other than clear/return
        issue(16'h2ABC);
        issue(INS_RET);
        issue(16'h3000);   // skip taken
        issue(16'h3155);
        issue(16'h4000);   // skip not taken
        issue(16'h5010);
        issue(16'h5011);   // 5xyN with N not 0
        issue(16'h9ABC);
        issue(16'hFFFF);
        issue(16'h1FFE);
        issue(16'h6E55);   // pc wraps past FFF
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    initial begin
        logic [CFG_W-1:0] cfg_word;
        for (int i = 0; i < STACK_DEPTH; i++) stk_written[i] = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        apb_read(START_ADDR_REG);
        for (int p = 0; p < NUM_PHASES; p++) begin
            cfg_word = $urandom();
            case (p)
                0: cfg_word[PC_W-1:0] = '0;
                1: cfg_word[PC_W-1:0] = '1;
                default: ;
            endcase
            apb_write(START_ADDR_REG, cfg_word);
            apb_read(START_ADDR_REG);
            burst_left = 0;
            if (p == 0) issue_directed();
            words_sent = 0;
            while (words_sent < PHASE_ITEMS) begin
                // hold the result side off so the block backs up into its input
                if (p == 1 && words_sent >= 40 && words_sent < 43) hold_off_req = 1'b1;
                issue_random();
            end
            drain();
        end
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && results_due == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/c8ie_pkg.sv
src/chip8_instruction_execute.sv
verif/chip8_exec_checker.sv
verif/chip8_instruction_execute_tb.sv
